>>> sv/tlpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpr_pkg
// Shared widths, register indexes and limits for the two-layer path rescaler.
// ----------------------------------------------------------------------------
package tlpr_pkg;

    localparam int COORD_W    = 32;
    localparam int RATIO_W    = 32;
    localparam int COUNT_BITS = 20;

    localparam int IN_W  = 3 * COORD_W;
    localparam int OUT_W = 3 * COORD_W + 2 * COUNT_BITS;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_TOP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_BOTTOM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PSEUDO_DEPTH = 2'd2;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 32'h0100_0000;
    localparam logic [COORD_W-1:0] DEPTH_RESET = 32'h0001_0000;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // quotient bits of the crossing fraction (Q0.31)
    localparam int DIV_STEPS = 31;

endpackage

>>> sv/two_layer_photon_path_rescaler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_layer_photon_path_rescaler_unit
// Rebuilds a baseline photon path for a two-layer medium, one point a request.
// ----------------------------------------------------------------------------
// Throughput: one request at a time; the next is accepted in the cycle after
//   the result is loaded. A crossing step runs the 31-step restoring divider
//   and then 8 jobs through the shared 32x32 multiplier pipeline.
// Reset: rst_n clears control, counts, previous point and position; registers
//   return to ratio 1.0 and pseudo depth 1.0.
// ----------------------------------------------------------------------------
module two_layer_photon_path_rescaler_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tlpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [tlpr_pkg::IN_W-1:0]    s_tdata,  // point_x, point_y, point_z
    input  logic                         s_tuser,  // first_point
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [tlpr_pkg::OUT_W-1:0]   m_tdata   // scaled_x, scaled_y, scaled_z,
                                                   // top_steps, bottom_steps
);
    import tlpr_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    // multiplier jobs; crossing steps use codes 0..7 in this order
    localparam logic [3:0] J_IX  = 4'd0;
    localparam logic [3:0] J_IY  = 4'd1;
    localparam logic [3:0] J_S1Z = 4'd2;
    localparam logic [3:0] J_S2Z = 4'd3;
    localparam logic [3:0] J_S1X = 4'd4;
    localparam logic [3:0] J_S1Y = 4'd5;
    localparam logic [3:0] J_S2X = 4'd6;
    localparam logic [3:0] J_S2Y = 4'd7;
    localparam logic [3:0] J_NX  = 4'd8;
    localparam logic [3:0] J_NY  = 4'd9;
    localparam logic [3:0] J_NZ  = 4'd10;

    localparam logic [3:0] LAST_CROSS = 4'd9;
    localparam logic [3:0] LAST_PLAIN = 4'd4;

    localparam logic signed [41:0] SUM_MAX = 42'sd2147483647;
    localparam logic signed [41:0] SUM_MIN = -42'sd2147483648;

    logic [2:0] state_reg, state_next;

    logic [RATIO_W-1:0]        ratio_top_reg, ratio_bot_reg;
    logic signed [COORD_W-1:0] depth_reg;

    logic signed [COORD_W-1:0] in_x_reg, in_y_reg, in_z_reg;
    logic                      in_first_reg;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic signed [COORD_W-1:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [COORD_W-1:0] sum_x_next, sum_y_next, sum_z_next;
    logic [COUNT_BITS-1:0]     top_cnt_reg, bot_cnt_reg, top_cnt_next, bot_cnt_next;
    logic                      top_reg, cross_reg;

    logic [31:0] rem_reg, b_reg;
    logic [30:0] t_reg;
    logic [4:0]  div_cnt_reg;

    logic signed [COORD_W-1:0] px_reg, py_reg;

    logic [3:0]  job_cnt_reg;
    logic [3:0]  job_code;
    logic [3:0]  job_last;

    logic        a_valid_reg, b_valid_reg;
    logic [3:0]  a_job_reg, b_job_reg;
    logic [31:0] a_mag_reg, a_mult_reg;
    logic        a_neg_reg, b_neg_reg;
    logic [63:0] prod_reg;

    logic                  m_valid_reg;
    logic [OUT_W-1:0]      m_data_reg;

    logic in_req, cfg_req, fin_load;

    assign cfg_ready = 1'b1;
    assign cfg_req   = cfg_valid & cfg_ready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_req    = s_tvalid & s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign fin_load  = (state_reg == ST_FIN) && (!m_valid_reg || m_tready);

    // ---------------- step setup ----------------
    logic        setup_top, setup_cross;
    logic [32:0] sa_diff, sb_diff, sa_mag, sb_mag;

    always_comb
    begin
        setup_top   = (prev_z_reg <= depth_reg);
        setup_cross = setup_top ? (in_z_reg > depth_reg) : (in_z_reg < depth_reg);
        sa_diff     = {depth_reg[31], depth_reg} - {prev_z_reg[31], prev_z_reg};
        sb_diff     = {in_z_reg[31], in_z_reg} - {prev_z_reg[31], prev_z_reg};
        sa_mag      = sa_diff[32] ? (~sa_diff + 33'd1) : sa_diff;
        sb_mag      = sb_diff[32] ? (~sb_diff + 33'd1) : sb_diff;
    end

    // ---------------- divider step ----------------
    logic [32:0] div_shift;
    logic        div_ge;
    logic [32:0] div_sub;

    always_comb
    begin
        div_shift = {rem_reg, 1'b0};
        div_ge    = (div_shift >= {1'b0, b_reg});
        div_sub   = div_shift - {1'b0, b_reg};
    end

    // ---------------- operand stage ----------------
    logic [RATIO_W-1:0]        r_here, r_other;
    logic signed [COORD_W-1:0] op_from, op_to;
    logic [31:0]               op_mult;
    logic [32:0]               op_diff, op_mag;
    logic                      a_valid_next;

    always_comb
    begin
        r_here   = top_reg ? ratio_top_reg : ratio_bot_reg;
        r_other  = top_reg ? ratio_bot_reg : ratio_top_reg;
        job_code = cross_reg ? {1'b0, job_cnt_reg[2:0]} : (J_NX + job_cnt_reg);
        job_last = cross_reg ? LAST_CROSS : LAST_PLAIN;
        a_valid_next = (state_reg == ST_MUL) && (job_cnt_reg < job_last - 4'd1);
        op_from = '0;
        op_to   = '0;
        op_mult = '0;
        unique case (job_code)
            J_IX:
            begin
                op_from = prev_x_reg; op_to = in_x_reg; op_mult = {1'b0, t_reg};
            end
            J_IY:
            begin
                op_from = prev_y_reg; op_to = in_y_reg; op_mult = {1'b0, t_reg};
            end
            J_S1Z:
            begin
                op_from = prev_z_reg; op_to = depth_reg; op_mult = r_here;
            end
            J_S2Z:
            begin
                op_from = depth_reg; op_to = in_z_reg; op_mult = r_other;
            end
            J_S1X:
            begin
                op_from = prev_x_reg; op_to = px_reg; op_mult = r_here;
            end
            J_S1Y:
            begin
                op_from = prev_y_reg; op_to = py_reg; op_mult = r_here;
            end
            J_S2X:
            begin
                op_from = px_reg; op_to = in_x_reg; op_mult = r_other;
            end
            J_S2Y:
            begin
                op_from = py_reg; op_to = in_y_reg; op_mult = r_other;
            end
            J_NX:
            begin
                op_from = prev_x_reg; op_to = in_x_reg; op_mult = r_here;
            end
            J_NY:
            begin
                op_from = prev_y_reg; op_to = in_y_reg; op_mult = r_here;
            end
            J_NZ:
            begin
                op_from = prev_z_reg; op_to = in_z_reg; op_mult = r_here;
            end
            default:
            begin
                op_from = '0; op_to = '0; op_mult = '0;
            end
        endcase
        op_diff = {op_to[31], op_to} - {op_from[31], op_from};
        op_mag  = op_diff[32] ? (~op_diff + 33'd1) : op_diff;
    end

    // ---------------- apply stage ----------------
    logic [63:0]               rnd_i, rnd_s;
    logic [32:0]               q_i;
    logic [39:0]               q_s;
    logic signed [COORD_W-1:0] ip_from, cur_sum;
    logic signed [33:0]        ip_full;
    logic signed [41:0]        sum_ext, q_ext, sum_full;
    logic signed [COORD_W-1:0] sum_sat;

    always_comb
    begin
        rnd_i   = prod_reg + 64'h0000_0000_4000_0000;
        rnd_s   = prod_reg + 64'h0000_0000_0080_0000;
        q_i     = rnd_i[63:31];
        q_s     = rnd_s[63:24];
        ip_from = (b_job_reg == J_IX) ? prev_x_reg : prev_y_reg;
        ip_full = b_neg_reg ? ({{2{ip_from[31]}}, ip_from} - {1'b0, q_i})
                            : ({{2{ip_from[31]}}, ip_from} + {1'b0, q_i});
        case (b_job_reg)
            J_S1X, J_S2X, J_NX: cur_sum = sum_x_reg;
            J_S1Y, J_S2Y, J_NY: cur_sum = sum_y_reg;
            default:            cur_sum = sum_z_reg;
        endcase
        sum_ext  = {{10{cur_sum[31]}}, cur_sum};
        q_ext    = {2'b00, q_s};
        sum_full = b_neg_reg ? (sum_ext - q_ext) : (sum_ext + q_ext);
        if (sum_full > SUM_MAX)
            sum_sat = 32'sh7FFF_FFFF;
        else if (sum_full < SUM_MIN)
            sum_sat = 32'sh8000_0000;
        else
            sum_sat = sum_full[31:0];
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next   = state_reg;
        sum_x_next   = sum_x_reg;
        sum_y_next   = sum_y_reg;
        sum_z_next   = sum_z_reg;
        top_cnt_next = top_cnt_reg;
        bot_cnt_next = bot_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_req)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                if (in_first_reg)
                begin
                    sum_x_next   = in_x_reg;
                    sum_y_next   = in_y_reg;
                    sum_z_next   = in_z_reg;
                    top_cnt_next = '0;
                    bot_cnt_next = '0;
                    state_next   = ST_FIN;
                end
                else
                begin
                    if (setup_top && top_cnt_reg != COUNT_MAX)
                        top_cnt_next = top_cnt_reg + 1'b1;
                    if (!setup_top && bot_cnt_reg != COUNT_MAX)
                        bot_cnt_next = bot_cnt_reg + 1'b1;
                    state_next = setup_cross ? ST_DIV : ST_MUL;
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == 5'(DIV_STEPS - 1))
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (b_valid_reg)
                begin
                    case (b_job_reg)
                        J_S1X, J_S2X, J_NX: sum_x_next = sum_sat;
                        J_S1Y, J_S2Y, J_NY: sum_y_next = sum_sat;
                        J_S1Z, J_S2Z, J_NZ: sum_z_next = sum_sat;
                        default: ;
                    endcase
                end
                if (job_cnt_reg == job_last)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (fin_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- control and state registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ratio_top_reg <= RATIO_RESET;
            ratio_bot_reg <= RATIO_RESET;
            depth_reg     <= DEPTH_RESET;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_z_reg    <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_z_reg     <= '0;
            top_cnt_reg   <= '0;
            bot_cnt_reg   <= '0;
            job_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sum_x_reg   <= sum_x_next;
            sum_y_reg   <= sum_y_next;
            sum_z_reg   <= sum_z_next;
            top_cnt_reg <= top_cnt_next;
            bot_cnt_reg <= bot_cnt_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= a_valid_reg;

            if (cfg_req)
            begin
                case (cfg_index)
                    CFG_RATIO_TOP:    ratio_top_reg <= cfg_data;
                    CFG_RATIO_BOTTOM: ratio_bot_reg <= cfg_data;
                    CFG_PSEUDO_DEPTH: depth_reg     <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == ST_SETUP)
                div_cnt_reg <= '0;
            else if (state_reg == ST_DIV)
                div_cnt_reg <= div_cnt_reg + 5'd1;

            if (state_reg == ST_MUL)
                job_cnt_reg <= job_cnt_reg + 4'd1;
            else
                job_cnt_reg <= '0;

            if (fin_load)
            begin
                prev_x_reg  <= in_x_reg;
                prev_y_reg  <= in_y_reg;
                prev_z_reg  <= in_z_reg;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (in_req)
        begin
            in_x_reg     <= s_tdata[31:0];
            in_y_reg     <= s_tdata[63:32];
            in_z_reg     <= s_tdata[95:64];
            in_first_reg <= s_tuser;
        end

        if (state_reg == ST_SETUP)
        begin
            top_reg   <= setup_top;
            cross_reg <= setup_cross;
            rem_reg   <= sa_mag[31:0];
            b_reg     <= sb_mag[31:0];
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg <= div_ge ? div_sub[31:0] : div_shift[31:0];
            t_reg   <= {t_reg[29:0], div_ge};
        end

        a_job_reg  <= job_code;
        a_mag_reg  <= op_mag[31:0];
        a_neg_reg  <= op_diff[32];
        a_mult_reg <= op_mult;

        b_job_reg  <= a_job_reg;
        b_neg_reg  <= a_neg_reg;
        prod_reg   <= a_mag_reg * a_mult_reg;

        if (state_reg == ST_MUL && b_valid_reg && b_job_reg == J_IX)
            px_reg <= ip_full[31:0];
        if (state_reg == ST_MUL && b_valid_reg && b_job_reg == J_IY)
            py_reg <= ip_full[31:0];

        if (fin_load)
            m_data_reg <= {bot_cnt_reg, top_cnt_reg, sum_z_reg, sum_y_reg, sum_x_reg};
    end

    // ---------------- assertions ----------------
    a_div_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < b_reg))
        else $error("divider remainder not below divisor");

    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("result raised outside finish state");

    a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SETUP && in_first_reg) |=>
            (top_cnt_reg == '0 && bot_cnt_reg == '0 && state_reg == ST_FIN))
        else $error("first point did not clear counts");

    a_pipe_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg || b_valid_reg) |-> (state_reg == ST_MUL))
        else $error("multiplier job outside multiply phase");

endmodule
